/* design/pcct_pkg.sv */
package pcct_pkg;

  // Motion sensitivity divider, power of two
  localparam int SENS_DIV = 4;
  localparam int SENS_SH  = $clog2(SENS_DIV);
  // Residue keeps -(SENS_DIV-1)..(SENS_DIV-1)
  localparam int RES_W    = SENS_SH + 1;
  // Residue plus one motion byte
  localparam int SUM_W    = 10;
  localparam int POS_W    = SUM_W + 1;
  localparam int DELTA_W  = 9;

  localparam logic [7:0] COLUMNS_RST = 8'd80;
  localparam logic [7:0] ROWS_RST    = 8'd25;
  localparam logic [7:0] COL_RST     = 8'd40;
  localparam logic [7:0] ROW_RST     = 8'd12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_EN = 2'd0,
    CFG_COLUMNS  = 2'd1,
    CFG_ROWS     = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_PS2    = 3'd0,
    MODE_USB    = 3'd1,
    MODE_TAKE_L = 3'd2,
    MODE_TAKE_R = 3'd3,
    MODE_WHEEL  = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    PH_HEAD  = 4'b0001,
    PH_X     = 4'b0010,
    PH_Y     = 4'b0100,
    PH_WHEEL = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [7:0]        aux_byte;
    logic signed [7:0] report_dx;
    logic signed [7:0] report_dy;
    logic [7:0]        report_buttons;
  } in_t;

  typedef struct packed {
    logic [7:0]         cursor_x;
    logic [7:0]         cursor_y;
    logic [2:0]         buttons;
    logic               left_pending;
    logic               right_pending;
    logic               packet_done;
    logic               taken;
    logic [7:0]         taken_x;
    logic [7:0]         taken_y;
    logic signed [15:0] wheel_sum;
  } out_t;

endpackage

/* design/pcct_axis.sv */
// One cursor axis: residue accumulate, divide toward zero, clamp to grid.
module pcct_axis (
  input  logic signed [pcct_pkg::RES_W-1:0]   residue,
  input  logic signed [pcct_pkg::DELTA_W-1:0] delta,
  input  logic [7:0]                          pos,
  input  logic [7:0]                          size,
  output logic signed [pcct_pkg::RES_W-1:0]   res_out,
  output logic [7:0]                          pos_out
);

  logic signed [pcct_pkg::SUM_W-1:0] sum;
  logic signed [pcct_pkg::SUM_W-1:0] sum_b;
  logic signed [pcct_pkg::SUM_W-1:0] quot;
  logic signed [pcct_pkg::SUM_W-1:0] rem;
  logic signed [pcct_pkg::POS_W-1:0] pos_sum;
  logic [7:0]                        top;

  always_comb begin
    sum   = pcct_pkg::SUM_W'(residue) + pcct_pkg::SUM_W'(delta);
    // bias negatives so the shift truncates toward zero
    sum_b = sum + (sum[pcct_pkg::SUM_W-1] ?
                   pcct_pkg::SUM_W'(pcct_pkg::SENS_DIV - 1) : pcct_pkg::SUM_W'(0));
    quot  = sum_b >>> pcct_pkg::SENS_SH;
    rem   = sum - (quot <<< pcct_pkg::SENS_SH);
    res_out = rem[pcct_pkg::RES_W-1:0];

    top     = (size == 8'd0) ? 8'd0 : size - 8'd1;
    pos_sum = $signed({3'b000, pos}) + pcct_pkg::POS_W'(quot);
    priority if (pos_sum[pcct_pkg::POS_W-1]) begin
      pos_out = 8'd0;
    end else if (pos_sum > $signed({3'b000, top})) begin
      pos_out = top;
    end else begin
      pos_out = pos_sum[7:0];
    end
  end

endmodule

/* design/pointer_packet_cursor_tracker.sv */
// Pointer packet cursor tracker.
//
// Input channel (in_valid / in_stall / in_data): one word per item. A word
// carries a PS/2 aux byte, a USB boot-mouse report, or a take request for
// the held left click, the held right click or the wheel sum. PS/2 bytes
// are framed into 3-byte packets (4 with the wheel enabled); a head byte
// without bit 3 set is dropped to regain sync.
// Result channel (out_valid / out_stall / out_data): exactly one word per
// input word, in order: cursor cell, latched buttons, pending clicks, the
// returned click, and the wheel sum (the sum before clearing on a take).
// Config port (cfg_we / cfg_index / cfg_wdata): wheel enable, columns, rows.
// Write only while no words are in flight.
// Path: each word is held in the input register, then its result in the
// result register, from which out_data is driven. Throughput: one word per
// cycle while out_stall is low, set by the single-pass update between the
// two registers; the state is updated as each word moves on.
// When out_stall holds the result register, the input register still takes
// one more word, then in_stall rises. Synchronous reset clears the pipeline,
// puts the cursor at column 40 row 12 and loads the default grid 80x25.
module pointer_packet_cursor_tracker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  pcct_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output pcct_pkg::out_t                       out_data,
  input  logic                                 cfg_we,
  input  logic [pcct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcct_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // ---------------- configuration registers ----------------
  logic       wheel_en_r;
  logic [7:0] columns_r;
  logic [7:0] rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_en_r <= 1'b0;
      columns_r  <= pcct_pkg::COLUMNS_RST;
      rows_r     <= pcct_pkg::ROWS_RST;
    end else if (cfg_we) begin
      unique case (pcct_pkg::cfg_idx_t'(cfg_index))
        pcct_pkg::CFG_WHEEL_EN: wheel_en_r <= cfg_wdata[0];
        pcct_pkg::CFG_COLUMNS:  columns_r  <= cfg_wdata;
        pcct_pkg::CFG_ROWS:     rows_r     <= cfg_wdata;
        default: ;  // unmapped index is ignored
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic          s1_valid_r;
  pcct_pkg::in_t s1_r;
  logic          out_valid_r;
  pcct_pkg::out_t out_r;
  pcct_pkg::out_t res_nxt;
  logic          s1_adv;
  logic          in_fire;

  // s1 moves on when the result register is empty or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_fire || (s1_valid_r && !s1_adv);
      out_valid_r <= s1_adv || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= in_data;
    end
    if (s1_adv) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- tracker state ----------------
  pcct_pkg::phase_t                    phase_r, phase_nxt;
  logic [7:0]                          first_byte_r, first_byte_nxt;
  logic [7:0]                          x_byte_r, x_byte_nxt;
  logic [7:0]                          y_byte_r, y_byte_nxt;
  logic signed [pcct_pkg::RES_W-1:0]   x_res_r, x_res_nxt;
  logic signed [pcct_pkg::RES_W-1:0]   y_res_r, y_res_nxt;
  logic [7:0]                          col_r, col_nxt;
  logic [7:0]                          row_r, row_nxt;
  logic [2:0]                          btn_r, btn_nxt;
  logic                                left_flag_r, left_flag_nxt;
  logic [7:0]                          left_col_r, left_col_nxt;
  logic [7:0]                          left_row_r, left_row_nxt;
  logic                                right_flag_r, right_flag_nxt;
  logic [7:0]                          right_col_r, right_col_nxt;
  logic [7:0]                          right_row_r, right_row_nxt;
  logic signed [15:0]                  wheel_r, wheel_nxt;

  // axis units
  logic signed [pcct_pkg::DELTA_W-1:0] dx, dy;
  logic signed [pcct_pkg::RES_W-1:0]   x_res_mv, y_res_mv;
  logic [7:0]                          col_mv, row_mv;
  logic [7:0]                          y_src;

  pcct_axis u_axis_x (
    .residue (x_res_r),
    .delta   (dx),
    .pos     (col_r),
    .size    (columns_r),
    .res_out (x_res_mv),
    .pos_out (col_mv)
  );

  pcct_axis u_axis_y (
    .residue (y_res_r),
    .delta   (dy),
    .pos     (row_r),
    .size    (rows_r),
    .res_out (y_res_mv),
    .pos_out (row_mv)
  );

  // motion source: USB report, or the framed PS/2 bytes (Y byte may be live)
  always_comb begin
    y_src = (phase_r == pcct_pkg::PH_Y) ? s1_r.aux_byte : y_byte_r;
    if (s1_r.mode == pcct_pkg::MODE_USB) begin
      dx = pcct_pkg::DELTA_W'(s1_r.report_dx);
      dy = pcct_pkg::DELTA_W'(0) - pcct_pkg::DELTA_W'(s1_r.report_dy);
    end else begin
      dx = pcct_pkg::DELTA_W'($signed(x_byte_r));
      dy = pcct_pkg::DELTA_W'(0) - pcct_pkg::DELTA_W'($signed(y_src));
    end
  end

  logic               apply;      // packet done or report applied
  logic [7:0]         btn_src;
  logic               wheel_add;
  logic signed [16:0] wheel_sum17;

  always_comb begin
    phase_nxt      = phase_r;
    first_byte_nxt = first_byte_r;
    x_byte_nxt     = x_byte_r;
    y_byte_nxt     = y_byte_r;
    apply          = 1'b0;
    wheel_add      = 1'b0;
    btn_src        = first_byte_r;

    x_res_nxt      = x_res_r;
    y_res_nxt      = y_res_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    btn_nxt        = btn_r;
    left_flag_nxt  = left_flag_r;
    left_col_nxt   = left_col_r;
    left_row_nxt   = left_row_r;
    right_flag_nxt = right_flag_r;
    right_col_nxt  = right_col_r;
    right_row_nxt  = right_row_r;

    res_nxt          = '0;

    unique case (s1_r.mode)
      pcct_pkg::MODE_PS2: begin
        unique case (phase_r)
          pcct_pkg::PH_HEAD: begin
            // resync: a head byte must have bit 3 set
            if (s1_r.aux_byte[3]) begin
              first_byte_nxt = s1_r.aux_byte;
              phase_nxt      = pcct_pkg::PH_X;
            end
          end
          pcct_pkg::PH_X: begin
            x_byte_nxt = s1_r.aux_byte;
            phase_nxt  = pcct_pkg::PH_Y;
          end
          pcct_pkg::PH_Y: begin
            y_byte_nxt = s1_r.aux_byte;
            if (wheel_en_r) begin
              phase_nxt = pcct_pkg::PH_WHEEL;
            end else begin
              phase_nxt = pcct_pkg::PH_HEAD;
              apply     = 1'b1;
            end
          end
          pcct_pkg::PH_WHEEL: begin
            phase_nxt = pcct_pkg::PH_HEAD;
            apply     = 1'b1;
            wheel_add = wheel_en_r;
          end
          default: phase_nxt = pcct_pkg::PH_HEAD;
        endcase
      end
      pcct_pkg::MODE_USB: begin
        apply   = 1'b1;
        btn_src = s1_r.report_buttons;
      end
      pcct_pkg::MODE_TAKE_L: begin
        if (left_flag_r) begin
          res_nxt.taken   = 1'b1;
          res_nxt.taken_x = left_col_r;
          res_nxt.taken_y = left_row_r;
          left_flag_nxt   = 1'b0;
        end
      end
      pcct_pkg::MODE_TAKE_R: begin
        if (right_flag_r) begin
          res_nxt.taken   = 1'b1;
          res_nxt.taken_x = right_col_r;
          res_nxt.taken_y = right_row_r;
          right_flag_nxt  = 1'b0;
        end
      end
      default: ;  // wheel take handled below; unused codes change nothing
    endcase

    if (apply) begin
      x_res_nxt = x_res_mv;
      y_res_nxt = y_res_mv;
      col_nxt   = col_mv;
      row_nxt   = row_mv;
      btn_nxt   = btn_src[2:0];
      // first press holds the position after this move
      if (btn_src[0] && !left_flag_r) begin
        left_flag_nxt = 1'b1;
        left_col_nxt  = col_mv;
        left_row_nxt  = row_mv;
      end
      if (btn_src[1] && !right_flag_r) begin
        right_flag_nxt = 1'b1;
        right_col_nxt  = col_mv;
        right_row_nxt  = row_mv;
      end
    end

    // wheel nibble, sign-extended, saturating sum
    wheel_sum17 = 17'(wheel_r) + 17'($signed(s1_r.aux_byte[3:0]));
    if (s1_r.mode == pcct_pkg::MODE_WHEEL) begin
      wheel_nxt = 16'sd0;
    end else if (!wheel_add) begin
      wheel_nxt = wheel_r;
    end else if (wheel_sum17[16] != wheel_sum17[15]) begin
      wheel_nxt = wheel_sum17[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      wheel_nxt = wheel_sum17[15:0];
    end

    res_nxt.cursor_x      = col_nxt;
    res_nxt.cursor_y      = row_nxt;
    res_nxt.buttons       = btn_nxt;
    res_nxt.left_pending  = left_flag_nxt;
    res_nxt.right_pending = right_flag_nxt;
    res_nxt.packet_done   = apply;
    res_nxt.wheel_sum     = (s1_r.mode == pcct_pkg::MODE_WHEEL) ? wheel_r : wheel_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= pcct_pkg::PH_HEAD;
      x_res_r      <= '0;
      y_res_r      <= '0;
      col_r        <= pcct_pkg::COL_RST;
      row_r        <= pcct_pkg::ROW_RST;
      btn_r        <= '0;
      left_flag_r  <= 1'b0;
      left_col_r   <= '0;
      left_row_r   <= '0;
      right_flag_r <= 1'b0;
      right_col_r  <= '0;
      right_row_r  <= '0;
      wheel_r      <= '0;
    end else if (s1_adv) begin
      phase_r      <= phase_nxt;
      x_res_r      <= x_res_nxt;
      y_res_r      <= y_res_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      btn_r        <= btn_nxt;
      left_flag_r  <= left_flag_nxt;
      left_col_r   <= left_col_nxt;
      left_row_r   <= left_row_nxt;
      right_flag_r <= right_flag_nxt;
      right_col_r  <= right_col_nxt;
      right_row_r  <= right_row_nxt;
      wheel_r      <= wheel_nxt;
    end
  end

  // framing bytes: always written before read
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      first_byte_r <= first_byte_nxt;
      x_byte_r     <= x_byte_nxt;
      y_byte_r     <= y_byte_nxt;
    end
  end

  // ---------------- assertions ----------------
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall with empty input register");

  a_take_left_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_r.mode == pcct_pkg::MODE_TAKE_L) |=> !left_flag_r)
    else $error("left click still pending after take");

  a_take_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_r.mode == pcct_pkg::MODE_TAKE_R && right_flag_r)
      |=> (out_valid_r && out_r.taken))
    else $error("held right click not returned");

  a_wheel_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_r.mode == pcct_pkg::MODE_WHEEL) |=> (wheel_r == 16'sd0))
    else $error("wheel sum not cleared");

  a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && apply) |=>
      (col_r == 8'd0 || col_r < columns_r))
    else $error("cursor column outside grid after move");

endmodule
